// File: src/assa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package assa_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OFFSET_W   = 33;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_UP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_OFS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BPP        = 3'd7;

  // Aspect modes.
  localparam logic [1:0] MODE_CROP    = 2'd0;
  localparam logic [1:0] MODE_FIT     = 2'd1;
  localparam logic [1:0] MODE_STRETCH = 2'd2;

  // Pixel size code that selects two bytes; every other code selects three.
  localparam logic [1:0] BPP_TWO = 2'd2;

  // Reset values.
  localparam int RST_OUT_WIDTH  = 320;
  localparam int RST_OUT_HEIGHT = 240;
  localparam int RST_SRC_WIDTH  = 320;
  localparam int RST_SRC_HEIGHT = 240;
  localparam logic [31:0] RST_DATA_OFS = 32'd54;
  localparam logic [1:0]  RST_BPP      = 2'd3;

endpackage

`default_nettype wire

// File: src/aspect_scale_source_address.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one item per cycle, every cycle; busy_o never rises and the receiver cannot stall.
// The restoring divider resolves one quotient bit per stage.
// Reset is asynchronous and active low: it clears all valid bits and loads the
// configuration registers with their documented defaults.
module aspect_scale_source_address import assa_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [COORD_BITS-1:0] out_x_i,
  input  wire logic [COORD_BITS-1:0] out_y_i,
  output logic                       valid_o,
  output logic      [COORD_BITS-1:0] source_x_o,
  output logic      [COORD_BITS-1:0] source_y_o,
  output logic      [COORD_BITS-1:0] stored_row_o,
  output logic      [OFFSET_W-1:0]   byte_offset_o,
  output logic                       is_black_o
);

  localparam int CB   = COORD_BITS;
  localparam int PW   = 2 * CB;             // product of two coordinates
  localparam int NB   = 2 * CB + 2;         // dividend and quotient width
  localparam int DB   = CB + 1;             // divisor width
  localparam int SW   = CB + 3;             // padded stride width
  localparam int RPW  = CB + SW;            // row times stride
  localparam int SUMW = (RPW + 1 > OFFSET_W + 1) ? RPW + 1 : OFFSET_W + 1;
  localparam int LAT  = NB + 6;

  // The block never refuses an item.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while no item is in
  // flight (the block does not enforce this); every pipeline stage reads them directly.
  // ---------------------------------------------------------------------------
  logic [CB-1:0] ow_q, oh_q, sw_q, sh_q;
  logic [1:0]    mode_q;
  logic          bup_q;
  logic [31:0]   pdo_q;
  logic [1:0]    bpp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ow_q   <= CB'(RST_OUT_WIDTH);
      oh_q   <= CB'(RST_OUT_HEIGHT);
      sw_q   <= CB'(RST_SRC_WIDTH);
      sh_q   <= CB'(RST_SRC_HEIGHT);
      mode_q <= MODE_CROP;
      bup_q  <= 1'b1;
      pdo_q  <= RST_DATA_OFS;
      bpp_q  <= RST_BPP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OUT_WIDTH:  ow_q   <= cfg_data_i[CB-1:0];
        REG_OUT_HEIGHT: oh_q   <= cfg_data_i[CB-1:0];
        REG_SRC_WIDTH:  sw_q   <= cfg_data_i[CB-1:0];
        REG_SRC_HEIGHT: sh_q   <= cfg_data_i[CB-1:0];
        REG_MODE:       mode_q <= cfg_data_i[1:0];
        REG_BOTTOM_UP:  bup_q  <= cfg_data_i[0];
        REG_DATA_OFS:   pdo_q  <= cfg_data_i[31:0];
        REG_BPP:        bpp_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // A dimension of zero is treated as one.
  logic [CB-1:0] dim_ow, dim_oh, dim_sw, dim_sh;
  assign dim_ow = (ow_q == '0) ? CB'(1) : ow_q;
  assign dim_oh = (oh_q == '0) ? CB'(1) : oh_q;
  assign dim_sw = (sw_q == '0) ? CB'(1) : sw_q;
  assign dim_sh = (sh_q == '0) ? CB'(1) : sh_q;

  logic is_stretch, is_crop;
  assign is_stretch = (mode_q == MODE_STRETCH);
  assign is_crop    = (mode_q == MODE_CROP);

  // ---------------------------------------------------------------------------
  // Stage 1: ratio cross products and the stretch-mode numerators.
  // ---------------------------------------------------------------------------
  logic          s1_vld_q;
  logic [CB-1:0] s1_ox_q, s1_oy_q;
  logic [PW-1:0] s1_hw_q, s1_wh_q, s1_stx_q, s1_sty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ox_q  <= out_x_i;
    s1_oy_q  <= out_y_i;
    s1_hw_q  <= PW'(dim_oh) * PW'(dim_sw);
    s1_wh_q  <= PW'(dim_ow) * PW'(dim_sh);
    s1_stx_q <= PW'(out_x_i) * PW'(dim_sw);
    s1_sty_q <= PW'(out_y_i) * PW'(dim_sh);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: pick the scale Sn/Sd (larger ratio for crop, smaller for fit, the
  // width ratio on a tie) and form the products that the centering needs.
  // ---------------------------------------------------------------------------
  logic          pick_h;
  logic [CB-1:0] sn, sd;
  assign pick_h = is_crop ? (s1_hw_q > s1_wh_q) : (s1_hw_q < s1_wh_q);
  assign sn     = pick_h ? dim_oh : dim_ow;
  assign sd     = pick_h ? dim_sh : dim_sw;

  logic          s2_vld_q;
  logic [CB-1:0] s2_sn_q;
  logic [PW-1:0] s2_wsn_q, s2_wsd_q, s2_hsn_q, s2_hsd_q, s2_pxd_q, s2_pyd_q;
  logic [PW-1:0] s2_stx_q, s2_sty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sn_q  <= sn;
    s2_wsn_q <= PW'(dim_sw) * PW'(sn);
    s2_wsd_q <= PW'(dim_ow) * PW'(sd);
    s2_hsn_q <= PW'(dim_sh) * PW'(sn);
    s2_hsd_q <= PW'(dim_oh) * PW'(sd);
    s2_pxd_q <= PW'(s1_ox_q) * PW'(sd);
    s2_pyd_q <= PW'(s1_oy_q) * PW'(sd);
    s2_stx_q <= s1_stx_q;
    s2_sty_q <= s1_sty_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: letterbox test and the dividend/divisor of each axis. Crop and
  // fit share the numerator w*Sn + 2*o*Sd - W*Sd, which is never negative in
  // crop mode and never negative for a fit pixel inside the picture.
  // ---------------------------------------------------------------------------
  logic [NB-1:0] px, py, base_x, base_y, lim_x, lim_y, nx, ny;
  logic [DB-1:0] dx, dy;
  logic          blk;

  assign px     = {1'b0, s2_pxd_q, 1'b0};
  assign py     = {1'b0, s2_pyd_q, 1'b0};
  assign base_x = px + NB'(s2_wsn_q);
  assign base_y = py + NB'(s2_hsn_q);
  assign lim_x  = NB'(s2_wsd_q) + NB'(s2_wsn_q);
  assign lim_y  = NB'(s2_hsd_q) + NB'(s2_hsn_q);
  assign blk    = !is_stretch && !is_crop &&
                  ((base_x < NB'(s2_wsd_q)) || (base_y < NB'(s2_hsd_q)) ||
                   (px >= lim_x) || (py >= lim_y));
  assign nx     = is_stretch ? NB'(s2_stx_q) : base_x - NB'(s2_wsd_q);
  assign ny     = is_stretch ? NB'(s2_sty_q) : base_y - NB'(s2_hsd_q);
  assign dx     = is_stretch ? DB'(dim_ow) : {s2_sn_q, 1'b0};
  assign dy     = is_stretch ? DB'(dim_oh) : {s2_sn_q, 1'b0};

  logic          s3_vld_q, s3_blk_q;
  logic [NB-1:0] s3_nx_q, s3_ny_q;
  logic [DB-1:0] s3_dx_q, s3_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_blk_q <= blk;
    s3_nx_q  <= nx;
    s3_ny_q  <= ny;
    s3_dx_q  <= dx;
    s3_dy_q  <= dy;
  end

  // ---------------------------------------------------------------------------
  // Truncating division, one quotient bit per stage on both axes.
  // ---------------------------------------------------------------------------
  logic          dv_vld, dv_blk;
  logic [NB-1:0] qx, qy;

  assa_div #(
    .NUM_W (NB),
    .DEN_W (DB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (s3_vld_q),
    .tag_i   (s3_blk_q),
    .num_x_i (s3_nx_q),
    .num_y_i (s3_ny_q),
    .den_x_i (s3_dx_q),
    .den_y_i (s3_dy_q),
    .vld_o   (dv_vld),
    .tag_o   (dv_blk),
    .quo_x_o (qx),
    .quo_y_o (qy)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: clamp to the source, flip the row for bottom-up files.
  // ---------------------------------------------------------------------------
  logic [CB-1:0] cx, cy, row;
  assign cx  = (qx >= NB'(dim_sw)) ? dim_sw - CB'(1) : qx[CB-1:0];
  assign cy  = (qy >= NB'(dim_sh)) ? dim_sh - CB'(1) : qy[CB-1:0];
  assign row = bup_q ? dim_sh - CB'(1) - cy : cy;

  logic          s4_vld_q, s4_blk_q;
  logic [CB-1:0] s4_sx_q, s4_sy_q, s4_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_blk_q <= dv_blk;
    s4_sx_q  <= cx;
    s4_sy_q  <= cy;
    s4_row_q <= row;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: padded stride and the two address products.
  // ---------------------------------------------------------------------------
  logic          bpp3;
  logic [SW-1:0] wb3, stride;
  assign bpp3   = (bpp_q != BPP_TWO);
  assign wb3    = SW'({dim_sw, 1'b0}) + (bpp3 ? SW'(dim_sw) : '0) + SW'(3);
  assign stride = {wb3[SW-1:2], 2'b00};

  logic            s5_vld_q, s5_blk_q;
  logic [CB-1:0]   s5_sx_q, s5_sy_q, s5_row_q;
  logic [RPW-1:0]  s5_rp_q;
  logic [CB+1:0]   s5_cb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_blk_q <= s4_blk_q;
    s5_sx_q  <= s4_sx_q;
    s5_sy_q  <= s4_sy_q;
    s5_row_q <= s4_row_q;
    s5_rp_q  <= RPW'(s4_row_q) * RPW'(stride);
    s5_cb_q  <= (CB+2)'({s4_sx_q, 1'b0}) + (bpp3 ? (CB+2)'(s4_sx_q) : '0);
  end

  // ---------------------------------------------------------------------------
  // Stage 6: final byte offset, output register. Letterbox items give zeros.
  // ---------------------------------------------------------------------------
  logic [SUMW-1:0] off_sum;
  assign off_sum = SUMW'(pdo_q) + SUMW'(s5_rp_q) + SUMW'(s5_cb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    is_black_o    <= s5_blk_q;
    source_x_o    <= s5_blk_q ? '0 : s5_sx_q;
    source_y_o    <= s5_blk_q ? '0 : s5_sy_q;
    stored_row_o  <= s5_blk_q ? '0 : s5_row_q;
    byte_offset_o <= s5_blk_q ? '0 : off_sum[OFFSET_W-1:0];
  end

`ifndef ASSERT_OFF
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(accept, LAT))
    else $error("result strobe does not follow an accepted item at fixed latency");

  a_black_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_black_o |-> source_x_o == '0 && source_y_o == '0 &&
                              stored_row_o == '0 && byte_offset_o == '0)
    else $error("letterbox item carries a nonzero address");

  a_clamp_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !is_black_o |-> source_x_o < dim_sw && source_y_o < dim_sh)
    else $error("source coordinate escaped the clamp");

  a_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !is_black_o && !bup_q |-> stored_row_o == source_y_o)
    else $error("top-down row differs from source row");
`endif

endmodule

`default_nettype wire

// File: src/assa_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-lane restoring divider, one quotient bit per register stage.
// A valid bit and a one-bit tag ride along with each item.
module assa_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic             tag_i,
  input  wire logic [NUM_W-1:0] num_x_i,
  input  wire logic [NUM_W-1:0] num_y_i,
  input  wire logic [DEN_W-1:0] den_x_i,
  input  wire logic [DEN_W-1:0] den_y_i,
  output logic                  vld_o,
  output logic                  tag_o,
  output logic      [NUM_W-1:0] quo_x_o,
  output logic      [NUM_W-1:0] quo_y_o
);

  localparam int LANES = 2;

  logic             vld_q [NUM_W];
  logic             tag_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W][LANES];
  logic [NUM_W-1:0] nq_q  [NUM_W][LANES];
  logic [DEN_W-1:0] den_q [NUM_W][LANES];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             vld_in;
    logic             tag_in;
    logic [DEN_W-1:0] rem_in [LANES];
    logic [NUM_W-1:0] nq_in  [LANES];
    logic [DEN_W-1:0] den_in [LANES];
    logic [DEN_W-1:0] rem_d  [LANES];
    logic [NUM_W-1:0] nq_d   [LANES];

    if (s == 0) begin : g_first
      assign vld_in    = vld_i;
      assign tag_in    = tag_i;
      assign rem_in[0] = '0;
      assign rem_in[1] = '0;
      assign nq_in[0]  = num_x_i;
      assign nq_in[1]  = num_y_i;
      assign den_in[0] = den_x_i;
      assign den_in[1] = den_y_i;
    end else begin : g_next
      assign vld_in    = vld_q[s-1];
      assign tag_in    = tag_q[s-1];
      assign rem_in[0] = rem_q[s-1][0];
      assign rem_in[1] = rem_q[s-1][1];
      assign nq_in[0]  = nq_q[s-1][0];
      assign nq_in[1]  = nq_q[s-1][1];
      assign den_in[0] = den_q[s-1][0];
      assign den_in[1] = den_q[s-1][1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] trial;
      logic           ge;
      logic [DEN_W:0] diff;
      assign trial    = {rem_in[l], nq_in[l][NUM_W-1]};
      assign ge       = trial >= {1'b0, den_in[l]};
      assign diff     = trial - {1'b0, den_in[l]};
      assign rem_d[l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign nq_d[l]  = {nq_in[l][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[s]    <= tag_in;
      rem_q[s][0] <= rem_d[0];
      rem_q[s][1] <= rem_d[1];
      nq_q[s][0]  <= nq_d[0];
      nq_q[s][1]  <= nq_d[1];
      den_q[s][0] <= den_in[0];
      den_q[s][1] <= den_in[1];
    end
  end

  assign vld_o   = vld_q[NUM_W-1];
  assign tag_o   = tag_q[NUM_W-1];
  assign quo_x_o = nq_q[NUM_W-1][0];
  assign quo_y_o = nq_q[NUM_W-1][1];

endmodule

`default_nettype wire

// File: verif/tb_aspect_scale_source_address.sv
`timescale 1ns / 1ps

module tb_aspect_scale_source_address;
  import assa_pkg::*;

  localparam int CW = 12;
  // The pipeline is 2*CW+8 deep; wait a little longer than that when draining.
  localparam int PIPE_DEPTH = 2 * CW + 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic [CW-1:0]         out_x_i;
  logic [CW-1:0]         out_y_i;
  logic                  valid_o;
  logic [CW-1:0]         source_x_o;
  logic [CW-1:0]         source_y_o;
  logic [CW-1:0]         stored_row_o;
  logic [OFFSET_W-1:0]   byte_offset_o;
  logic                  is_black_o;

  aspect_scale_source_address #(.COORD_BITS(CW)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .out_x_i(out_x_i), .out_y_i(out_y_i), .valid_o(valid_o),
    .source_x_o(source_x_o), .source_y_o(source_y_o), .stored_row_o(stored_row_o),
    .byte_offset_o(byte_offset_o), .is_black_o(is_black_o)
  );

  // One source address as the block reports it.
  typedef struct packed {
    logic [CW-1:0]       sx;
    logic [CW-1:0]       sy;
    logic [CW-1:0]       row;
    logic [OFFSET_W-1:0] ofs;
    logic                black;
  } addr_t;

  // A row of the directed table. When has_exp is set, the expected address is
  // typed in directly; otherwise the predictor supplies it.
  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    bit            has_exp;
    addr_t         exp;
  } dir_row_t;

  // Shadow copy of the configuration registers.
  logic [CW-1:0] sh_out_w, sh_out_h, sh_src_w, sh_src_h;
  logic [1:0]    sh_mode;
  logic          sh_bottom_up;
  logic [31:0]   sh_data_ofs;
  logic [1:0]    sh_bpp;

  addr_t expected_addrs[$];
  int    n_errors;
  int    n_checked;
  int    n_black;
  int    n_items;
  int    n_cfg_sets;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint dim_of(logic [CW-1:0] v);
    return (v == '0) ? 64'sd1 : longint'(v);
  endfunction

  // Nearest-neighbour source address under the current shadow configuration.
  function automatic addr_t source_address(logic [CW-1:0] x, logic [CW-1:0] y);
    longint ow, oh, sw, shh, ox, oy, sx, sy, sn, sd, ax, ay, px, py, bpp, stride, row;
    addr_t a;
    ow = dim_of(sh_out_w);
    oh = dim_of(sh_out_h);
    sw = dim_of(sh_src_w);
    shh = dim_of(sh_src_h);
    ox = longint'(x);
    oy = longint'(y);
    a = '0;
    if (sh_mode == MODE_STRETCH) begin
      sx = (ox * sw) / ow;
      sy = (oy * shh) / oh;
    end else if (sh_mode == MODE_CROP) begin
      // Crop scales by the larger ratio, so one axis overflows and is centred.
      if (oh * sw > ow * shh) begin
        sn = oh; sd = shh;
      end else begin
        sn = ow; sd = sw;
      end
      sx = (sw * sn - ow * sd + 2 * ox * sd) / (2 * sn);
      sy = (shh * sn - oh * sd + 2 * oy * sd) / (2 * sn);
    end else begin
      // Fit (and the unused mode code) scales by the smaller ratio; a tie goes to x.
      if (oh * sw < ow * shh) begin
        sn = oh; sd = shh;
      end else begin
        sn = ow; sd = sw;
      end
      ax = ow * sd - sw * sn;
      ay = oh * sd - shh * sn;
      px = 2 * ox * sd;
      py = 2 * oy * sd;
      if (px < ax || py < ay || px >= ow * sd + sw * sn || py >= oh * sd + shh * sn) begin
        a.black = 1'b1;
        return a;
      end
      sx = (px - ax) / (2 * sn);
      sy = (py - ay) / (2 * sn);
    end
    if (sx < 0) sx = 0;
    if (sx >= sw) sx = sw - 1;
    if (sy < 0) sy = 0;
    if (sy >= shh) sy = shh - 1;
    bpp = (sh_bpp == BPP_TWO) ? 2 : 3;
    stride = ((sw * bpp + 3) / 4) * 4;
    row = sh_bottom_up ? (shh - 1 - sy) : sy;
    a.sx = sx[CW-1:0];
    a.sy = sy[CW-1:0];
    a.row = row[CW-1:0];
    a.ofs = OFFSET_W'(longint'(sh_data_ofs) + row * stride + sx * bpp);
    return a;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_OUT_WIDTH:  sh_out_w     = data[CW-1:0];
      REG_OUT_HEIGHT: sh_out_h     = data[CW-1:0];
      REG_SRC_WIDTH:  sh_src_w     = data[CW-1:0];
      REG_SRC_HEIGHT: sh_src_h     = data[CW-1:0];
      REG_MODE:       sh_mode      = data[1:0];
      REG_BOTTOM_UP:  sh_bottom_up = data[0];
      REG_DATA_OFS:   sh_data_ofs  = data;
      REG_BPP:        sh_bpp       = data[1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [CW-1:0] ow, logic [CW-1:0] oh, logic [CW-1:0] sw,
                           logic [CW-1:0] shh, logic [1:0] mode, logic bu,
                           logic [31:0] dofs, logic [1:0] bpp);
    cfg_write(REG_OUT_WIDTH, 32'(ow));
    cfg_write(REG_OUT_HEIGHT, 32'(oh));
    cfg_write(REG_SRC_WIDTH, 32'(sw));
    cfg_write(REG_SRC_HEIGHT, 32'(shh));
    cfg_write(REG_MODE, 32'(mode));
    cfg_write(REG_BOTTOM_UP, 32'(bu));
    cfg_write(REG_DATA_OFS, dofs);
    cfg_write(REG_BPP, 32'(bpp));
    n_cfg_sets++;
  endtask

  // Wait until every expected result is back, then let the pipeline settle.
  task automatic drain();
    start_i <= 1'b0;
    while (expected_addrs.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  // Present one item, with a random idle gap first, and record its expectation.
  task automatic send_item(logic [CW-1:0] x, logic [CW-1:0] y, bit has_exp, addr_t exp);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    out_x_i <= x;
    out_y_i <= y;
    do @(posedge clk_i); while (busy_o);
    // The predictor runs at acceptance so that it sees the live configuration.
    expected_addrs.push_back(has_exp ? exp : source_address(x, y));
    n_items++;
    // Keep start high through back-to-back items; it is lowered only when a gap follows or on a drain.
  endtask

  task automatic send_random(int count);
    logic [CW-1:0] x, y;
    int ow, oh;
    for (int i = 0; i < count; i++) begin
      ow = int'(dim_of(sh_out_w));
      oh = int'(dim_of(sh_out_h));
      // Mostly coordinates inside the output raster, sometimes anywhere.
      if ($urandom_range(0, 4) == 0) begin
        x = CW'($urandom);
        y = CW'($urandom);
      end else begin
        x = CW'($urandom_range(0, ow - 1));
        y = CW'($urandom_range(0, oh - 1));
      end
      send_item(x, y, 1'b0, '0);
    end
  endtask

  function automatic logic [CW-1:0] rand_dim();
    case ($urandom_range(0, 5))
      0: return CW'($urandom_range(0, 2));
      1: return CW'(4095 - $urandom_range(0, 1));
      2: return CW'($urandom);
      default: return CW'($urandom_range(1, 64));
    endcase
  endfunction

  // Results come one per strobe and cannot be held off, so they are checked
  // against the oldest expectation at the edge that ends the strobe cycle.
  always @(posedge clk_i) begin
    addr_t got, want;
    if (rst_ni && valid_o) begin
      got = '{source_x_o, source_y_o, stored_row_o, byte_offset_o, is_black_o};
      if (expected_addrs.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        want = expected_addrs.pop_front();
        n_checked++;
        if (want.black) n_black++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: sx %0d/%0d sy %0d/%0d row %0d/%0d ofs %0d/%0d black %0b/%0b",
                     got.sx, want.sx, got.sy, want.sy, got.row, want.row,
                     got.ofs, want.ofs, got.black, want.black);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("tb_aspect_scale_source_address: FAIL");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[$];
    addr_t    blk;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    out_x_i    = '0;
    out_y_i    = '0;
    n_errors   = 0;
    n_checked  = 0;
    n_black    = 0;
    n_items    = 0;
    n_cfg_sets = 0;
    sh_out_w = CW'(RST_OUT_WIDTH);
    sh_out_h = CW'(RST_OUT_HEIGHT);
    sh_src_w = CW'(RST_SRC_WIDTH);
    sh_src_h = CW'(RST_SRC_HEIGHT);
    sh_mode = MODE_CROP;
    sh_bottom_up = 1'b1;
    sh_data_ofs = RST_DATA_OFS;
    sh_bpp = RST_BPP;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset configuration: identity crop of 320x240, bottom-up,
    // three bytes per pixel, stride 960 and data offset 54.
    dir_rows.push_back('{12'd0, 12'd0, 1'b1, '{12'd0, 12'd0, 12'd239, 33'd229494, 1'b0}});
    dir_rows.push_back('{12'd319, 12'd239, 1'b1, '{12'd319, 12'd239, 12'd0, 33'd1011, 1'b0}});
    dir_rows.push_back('{12'd4095, 12'd4095, 1'b1, '{12'd319, 12'd239, 12'd0, 33'd1011, 1'b0}});
    dir_rows.push_back('{12'd4095, 12'd0, 1'b0, '0});
    dir_rows.push_back('{12'd0, 12'd4095, 1'b0, '0});
    dir_rows.push_back('{12'hAAA, 12'h555, 1'b0, '0});
    dir_rows.push_back('{12'h555, 12'hAAA, 1'b0, '0});
    foreach (dir_rows[i]) send_item(dir_rows[i].x, dir_rows[i].y, dir_rows[i].has_exp,
                                    dir_rows[i].exp);
    drain();

    // Fit a square source onto a wide raster: pillar-box border on the left and right.
    write_all(12'd16, 12'd8, 12'd4, 12'd4, MODE_FIT, 1'b0, 32'hFFFF_FFFF, 2'd2);
    blk = '0;
    blk.black = 1'b1;
    dir_rows.delete();
    dir_rows.push_back('{12'd0, 12'd0, 1'b1, blk});
    dir_rows.push_back('{12'd15, 12'd7, 1'b1, blk});
    dir_rows.push_back('{12'd4095, 12'd4095, 1'b1, blk});
    dir_rows.push_back('{12'd4, 12'd0, 1'b0, '0});
    dir_rows.push_back('{12'd11, 12'd7, 1'b0, '0});
    dir_rows.push_back('{12'd8, 12'd4, 1'b0, '0});
    foreach (dir_rows[i]) send_item(dir_rows[i].x, dir_rows[i].y, dir_rows[i].has_exp,
                                    dir_rows[i].exp);
    drain();

    // Zero dimensions act as one, the unused mode code acts as fit, and a zero offset.
    write_all(12'd0, 12'd0, 12'd0, 12'd0, 2'd3, 1'b1, 32'd0, 2'd0);
    send_item(12'd0, 12'd0, 1'b0, '0);
    send_item(12'd1, 12'd1, 1'b0, '0);
    drain();
    write_all(12'd4095, 12'd4095, 12'd4095, 12'd1, MODE_STRETCH, 1'b1, 32'd0, 2'd1);
    send_item(12'd4095, 12'd4095, 1'b0, '0);
    send_item(12'd0, 12'd2048, 1'b0, '0);
    drain();

    // Random part: several configurations, each followed by a burst of items.
    for (int phase = 0; phase < 30; phase++) begin
      write_all(rand_dim(), rand_dim(), rand_dim(), rand_dim(), 2'($urandom_range(0, 3)),
                1'($urandom), (phase % 5 == 0) ? 32'hFFFF_FFFF : $urandom, 2'($urandom));
      send_random(50);
      drain();
    end

    $display("Covered %0d items over %0d register settings; %0d results checked, %0d black.",
             n_items, n_cfg_sets, n_checked, n_black);
    if (n_errors == 0) begin
      $display("tb_aspect_scale_source_address: PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb_aspect_scale_source_address: FAIL");
    end
    $finish;
  end

endmodule
